// ===== rtl/ats_frame_parser_macros.svh =====
// Assertion macros shared by the ATS frame parser RTL.
// Expects signals named clock and reset in the using module.
`ifndef ATS_FRAME_PARSER_MACROS_SVH
`define ATS_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ATS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ats_frame_parser: assertion failed");

// next-cycle implication, disabled during reset
`define ATS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ats_frame_parser: assertion failed");

`endif

// ===== rtl/ats_pkg.sv =====
// Types, codes and decode tables for the ATS frame parser.
// No dependencies; used by ats_frame_parser.
package ats_pkg;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BAD_COUNT = 4'd1,
      ST_TL_OVER   = 4'd2,
      ST_TL_ZERO   = 4'd3,
      ST_NO_TA     = 4'd4,
      ST_NO_TB     = 4'd5,
      ST_NO_TC     = 4'd6,
      ST_SHORT_IND = 4'd7,
      ST_BAD_TLV   = 4'd8
   } status_type;

   typedef struct packed {
      logic [3:0] fsci;
      logic       same_div;
      logic [2:0] ds;
      logic [2:0] dr;
      logic [3:0] fwi;
      logic [3:0] sfgi;
      logic       cid;
      logic       nad;
   } iface_type;

   localparam iface_type IFACE_DEFAULT = '{
      fsci: 4'd2, same_div: 1'b0, ds: 3'd0, dr: 3'd0,
      fwi: 4'd4, sfgi: 4'd0, cid: 1'b1, nad: 1'b0
   };

   localparam logic [7:0] CAT_STATUS    = 8'h00;  // category with trailing indicator
   localparam logic [7:0] CAT_TLV       = 8'h80;  // category with TLV area only
   localparam logic [3:0] TAG_INDICATOR = 4'd8;
   localparam logic [3:0] NIBBLE_RFU    = 4'd15;
   localparam logic [3:0] FWI_DEFAULT   = 4'd4;
   localparam logic [3:0] SFGI_DEFAULT  = 4'd0;
   localparam logic [3:0] IND_FULL_LEN  = 4'd3;

   function automatic logic [12:0] fsc_decode(input logic [3:0] fsci);
      logic [12:0] fsc;
      case (fsci)
         4'd0:    fsc = 13'd16;
         4'd1:    fsc = 13'd24;
         4'd2:    fsc = 13'd32;
         4'd3:    fsc = 13'd40;
         4'd4:    fsc = 13'd48;
         4'd5:    fsc = 13'd64;
         4'd6:    fsc = 13'd96;
         4'd7:    fsc = 13'd128;
         4'd8:    fsc = 13'd256;
         4'd9:    fsc = 13'd512;
         4'd10:   fsc = 13'd1024;
         4'd11:   fsc = 13'd2048;
         default: fsc = 13'd4096;
      endcase
      return fsc;
   endfunction

endpackage

// ===== rtl/ats_frame_parser.sv =====
// ATS frame parser top level: byte stream in, one parsed record per frame out.
// Depends on ats_pkg and ats_frame_parser_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | data_byte, last_byte
//   rsp     | out       | rsp_valid/stall    | status and parsed record fields
//
// One byte per cycle: a byte is held in the input register, is parsed against
// the running state there, and the last byte loads the result register.
// Bytes of the next frame keep flowing while a result waits; only a last byte
// stalls behind a result that has not been taken.
// Synchronous active-high reset clears all control and parser state.
`include "ats_frame_parser_macros.svh"

module ats_frame_parser #(
   parameter int MAX_FRAME = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [12:0] rsp_frame_size,
   output logic        rsp_same_divisor_required,
   output logic [2:0]  rsp_send_divisors,
   output logic [2:0]  rsp_receive_divisors,
   output logic [3:0]  rsp_wait_integer,
   output logic [3:0]  rsp_guard_integer,
   output logic        rsp_cid_capable,
   output logic        rsp_nad_capable,
   output logic [7:0]  rsp_category_byte,
   output logic [1:0]  rsp_indicator_count,
   output logic [23:0] rsp_indicator_bytes
);

   localparam int PosW = $clog2(MAX_FRAME + 1);
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        accept, advance, finish;

   // parser state
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [7:0]        tl_ff, tl_in, tl_upd;
   logic [7:0]        fmt_ff, fmt_in, fmt_upd;
   logic [7:0]        cat_ff, cat_in, cat_upd;
   ats_pkg::iface_type iface_ff, iface_in, iface_upd;
   logic [3:0]        rem_ff, rem_in, rem_upd;
   logic [3:0]        tag_ff, tag_in, tag_upd;
   logic [23:0]       shift_ff, shift_in, shift_upd;
   logic [3:0]        ilen_ff, ilen_in, ilen_upd;
   logic              seen_ff, seen_in, seen_upd;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  status_ff;
   logic [12:0] fsize_ff;
   ats_pkg::iface_type riface_ff;
   logic [7:0]  rcat_ff;
   logic [1:0]  icount_ff;
   logic [23:0] ibytes_ff;
   logic        rsp_err;

   logic [7:0]  b;
   logic [9:0]  pos10, tl10, tlu10, k10;
   logic [1:0]  ni, ni_upd;
   logic [9:0]  idx10;
   logic        take, is_fmt, is_iface, is_cat, is_hist, tlv_byte, trail_byte;
   logic        sel_ta, sel_tb, sel_tc;
   logic [7:0]  ta;
   ats_pkg::status_type st;
   logic [1:0]  icount;
   logic [23:0] ibytes;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign finish    = advance && in_last_ff;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // byte classification
   assign b      = in_data_ff;
   assign pos10  = 10'(pos_ff);
   assign tl10   = {2'b00, tl_ff};
   assign ni     = 2'(fmt_ff[4]) + 2'(fmt_ff[5]) + 2'(fmt_ff[6]);
   assign k10    = pos10 - 10'd2;
   assign take   = (pos_ff != '0) && (pos10 < tl10);
   assign is_fmt = take && (pos10 == 10'd1);
   assign is_iface = take && (pos10 >= 10'd2) && (k10 < 10'(ni));
   assign is_cat   = take && (pos10 >= 10'd2) && (k10 == 10'(ni));
   assign is_hist  = take && (pos10 >= 10'd2) && (k10 > 10'(ni))
                     && (cat_ff == ats_pkg::CAT_STATUS || cat_ff == ats_pkg::CAT_TLV);
   // category 0x00 keeps its last three bytes for the mandatory indicator
   assign tlv_byte   = is_hist && (cat_ff == ats_pkg::CAT_TLV || pos10 + 10'd3 < tl10);
   assign trail_byte = is_hist && (cat_ff == ats_pkg::CAT_STATUS)
                       && (pos10 + 10'd3 >= tl10) && (tl10 >= 10'd6 + 10'(ni));

   // which interface byte this one is, from the announce bits
   assign sel_ta = fmt_ff[4] && (k10 == 10'd0);
   assign sel_tb = fmt_ff[5] && (k10 == 10'(fmt_ff[4]));
   assign sel_tc = fmt_ff[6] && (k10 == 10'(fmt_ff[4]) + 10'(fmt_ff[5]));
   assign ta     = b[3] ? 8'h00 : b;  // RFU bit set: treat TA1 as zero

   always_comb begin
      tl_upd    = (pos_ff == '0) ? b : tl_ff;
      fmt_upd   = fmt_ff;
      cat_upd   = cat_ff;
      iface_upd = iface_ff;
      rem_upd   = rem_ff;
      tag_upd   = tag_ff;
      shift_upd = shift_ff;
      ilen_upd  = ilen_ff;
      seen_upd  = seen_ff;
      if (is_fmt) begin
         fmt_upd        = b;
         iface_upd.fsci = b[3:0];
      end
      if (is_iface && sel_ta) begin
         iface_upd.same_div = ta[7];
         iface_upd.ds       = ta[6:4];
         iface_upd.dr       = ta[2:0];
      end
      if (is_iface && sel_tb) begin
         iface_upd.fwi  = (b[7:4] == ats_pkg::NIBBLE_RFU) ? ats_pkg::FWI_DEFAULT : b[7:4];
         iface_upd.sfgi = (b[3:0] == ats_pkg::NIBBLE_RFU) ? ats_pkg::SFGI_DEFAULT : b[3:0];
      end
      if (is_iface && sel_tc) begin
         iface_upd.cid = b[1];
         iface_upd.nad = b[0];
      end
      if (is_cat) begin
         cat_upd = b;
      end
      if (tlv_byte) begin
         if (rem_ff == 4'd0) begin
            tag_upd = b[7:4];
            rem_upd = b[3:0];
            if (b[7:4] == ats_pkg::TAG_INDICATOR) begin
               seen_upd  = 1'b1;
               ilen_upd  = b[3:0];
               shift_upd = '0;
            end
         end else begin
            rem_upd = rem_ff - 4'd1;
            if (tag_ff == ats_pkg::TAG_INDICATOR) begin
               shift_upd = {shift_ff[15:0], b};
            end
         end
      end
      if (trail_byte && !seen_ff) begin
         shift_upd = {shift_ff[15:0], b};
         ilen_upd  = ats_pkg::IND_FULL_LEN;
      end
   end

   // end-of-frame checks on the updated state
   assign tlu10  = {2'b00, tl_upd};
   assign ni_upd = 2'(fmt_upd[4]) + 2'(fmt_upd[5]) + 2'(fmt_upd[6]);
   assign idx10  = 10'd2 + 10'(ni_upd);

   always_comb begin
      st = ats_pkg::ST_OK;
      if (pos_ff >= PosMax) begin
         st = ats_pkg::ST_BAD_COUNT;
      end else if (tlu10 > pos10 + 10'd1) begin
         st = ats_pkg::ST_TL_OVER;
      end else if (tl_upd == 8'd0) begin
         st = ats_pkg::ST_TL_ZERO;
      end else if (tl_upd == 8'd1) begin
         st = ats_pkg::ST_OK;
      end else if (fmt_upd[4] && tlu10 <= 10'd2) begin
         st = ats_pkg::ST_NO_TA;
      end else if (fmt_upd[5] && tlu10 <= 10'd2 + 10'(fmt_upd[4])) begin
         st = ats_pkg::ST_NO_TB;
      end else if (fmt_upd[6] && tlu10 <= 10'd2 + 10'(fmt_upd[4]) + 10'(fmt_upd[5])) begin
         st = ats_pkg::ST_NO_TC;
      end else if (idx10 < tlu10) begin
         if (cat_upd == ats_pkg::CAT_STATUS && tlu10 < idx10 + 10'd4) begin
            st = ats_pkg::ST_SHORT_IND;
         end else if ((cat_upd == ats_pkg::CAT_STATUS || cat_upd == ats_pkg::CAT_TLV)
                      && rem_upd != 4'd0) begin
            st = ats_pkg::ST_BAD_TLV;
         end
      end
   end

   always_comb begin
      icount = 2'd0;
      ibytes = '0;
      case (ilen_upd)
         4'd1: begin
            icount = 2'd1;
            ibytes = {16'h0000, shift_upd[7:0]};
         end
         4'd2: begin
            icount = 2'd2;
            ibytes = {8'h00, shift_upd[15:0]};
         end
         4'd3: begin
            icount = 2'd3;
            ibytes = shift_upd;
         end
         default: begin
            icount = 2'd0;
            ibytes = '0;
         end
      endcase
   end

   // state next values: a finished frame returns to the reset state
   always_comb begin
      pos_in   = pos_ff;
      tl_in    = tl_ff;
      fmt_in   = fmt_ff;
      cat_in   = cat_ff;
      iface_in = iface_ff;
      rem_in   = rem_ff;
      tag_in   = tag_ff;
      shift_in = shift_ff;
      ilen_in  = ilen_ff;
      seen_in  = seen_ff;
      if (finish) begin
         pos_in   = '0;
         tl_in    = '0;
         fmt_in   = '0;
         cat_in   = '0;
         iface_in = ats_pkg::IFACE_DEFAULT;
         rem_in   = '0;
         tag_in   = '0;
         shift_in = '0;
         ilen_in  = '0;
         seen_in  = 1'b0;
      end else if (advance) begin
         pos_in   = (pos_ff == PosMax) ? pos_ff : pos_ff + PosW'(1);
         tl_in    = tl_upd;
         fmt_in   = fmt_upd;
         cat_in   = cat_upd;
         iface_in = iface_upd;
         rem_in   = rem_upd;
         tag_in   = tag_upd;
         shift_in = shift_upd;
         ilen_in  = ilen_upd;
         seen_in  = seen_upd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         tl_ff        <= '0;
         fmt_ff       <= '0;
         cat_ff       <= '0;
         iface_ff     <= ats_pkg::IFACE_DEFAULT;
         rem_ff       <= '0;
         tag_ff       <= '0;
         shift_ff     <= '0;
         ilen_ff      <= '0;
         seen_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         tl_ff        <= tl_in;
         fmt_ff       <= fmt_in;
         cat_ff       <= cat_in;
         iface_ff     <= iface_in;
         rem_ff       <= rem_in;
         tag_ff       <= tag_in;
         shift_ff     <= shift_in;
         ilen_ff      <= ilen_in;
         seen_ff      <= seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (finish) begin
         status_ff <= 4'(st);
         if (st == ats_pkg::ST_OK) begin
            fsize_ff  <= ats_pkg::fsc_decode(iface_upd.fsci);
            riface_ff <= iface_upd;
            rcat_ff   <= cat_upd;
            icount_ff <= icount;
            ibytes_ff <= ibytes;
         end else begin
            fsize_ff  <= '0;
            riface_ff <= '0;
            rcat_ff   <= '0;
            icount_ff <= '0;
            ibytes_ff <= '0;
         end
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = status_ff;
   assign rsp_frame_size            = fsize_ff;
   assign rsp_same_divisor_required = riface_ff.same_div;
   assign rsp_send_divisors         = riface_ff.ds;
   assign rsp_receive_divisors      = riface_ff.dr;
   assign rsp_wait_integer          = riface_ff.fwi;
   assign rsp_guard_integer         = riface_ff.sfgi;
   assign rsp_cid_capable           = riface_ff.cid;
   assign rsp_nad_capable           = riface_ff.nad;
   assign rsp_category_byte         = rcat_ff;
   assign rsp_indicator_count       = icount_ff;
   assign rsp_indicator_bytes       = ibytes_ff;

   assign rsp_err = rsp_valid_ff && (status_ff != 4'(ats_pkg::ST_OK));

   `ATS_ASSERT_IMP(a_err_fields_zero, rsp_err, fsize_ff == '0 && icount_ff == '0 && rcat_ff == '0)
   `ATS_ASSERT_IMP(a_no_ind_no_bytes, rsp_valid_ff && icount_ff == 2'd0, ibytes_ff == '0)
   `ATS_ASSERT_NXT(a_frame_restart, finish, pos_ff == '0 && !seen_ff && rem_ff == '0)
   `ATS_ASSERT_IMP(a_stall_only_last, req_stall, in_valid_ff && in_last_ff && rsp_valid_ff)

endmodule
